>>> sv/nrps_pkg.sv
package nrps_pkg;

    // Capacity of one set
    localparam int MaxItems = 32;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CntW     = $clog2(MaxItems + 1);
    localparam int DistW    = 34;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [CntW-1:0] t_cnt;

    // One stored rectangle: edges are inclusive
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [16:0] right;
        logic signed [16:0] bottom;
        logic [DistW-1:0]   sq_dist;
    } t_entry;

    // Result outcome codes
    localparam logic [1:0] OutSingle   = 2'd0;
    localparam logic [1:0] OutRule     = 2'd1;
    localparam logic [1:0] OutFallback = 2'd2;

endpackage

>>> sv/nrps_store.sv
module nrps_store (
    input  logic             i_clk,
    input  logic             i_we,
    input  nrps_pkg::t_idx   i_waddr,
    input  nrps_pkg::t_entry i_wdata,
    input  nrps_pkg::t_idx   i_raddr,
    output nrps_pkg::t_entry o_rdata
);

    nrps_pkg::t_entry r_mem [nrps_pkg::MaxItems];
    nrps_pkg::t_entry r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/nrps_dist.sv
module nrps_dist (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [15:0]           i_left,
    input  logic signed [15:0]           i_top,
    input  logic signed [16:0]           i_right,
    input  logic signed [16:0]           i_bottom,
    input  logic signed [15:0]           i_cur_x,
    input  logic signed [15:0]           i_cur_y,
    output logic                         o_done,
    output logic [nrps_pkg::DistW-1:0]   o_dist
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DX   = 3'd1;
    localparam logic [2:0] PH_SQX  = 3'd2;
    localparam logic [2:0] PH_SQY  = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0]                  r_ph;
    logic [2:0]                  n_ph;
    logic signed [17:0]          r_d;
    logic [nrps_pkg::DistW-1:0]  r_sq;
    logic [nrps_pkg::DistW-1:0]  r_acc;

    logic signed [17:0] sum_x;
    logic signed [17:0] sum_y;
    logic signed [17:0] half_x;
    logic signed [17:0] half_y;
    logic signed [17:0] d_x;
    logic signed [17:0] d_y;
    logic signed [35:0] prod;

    // Centre per axis, halved toward zero, then offset from the cursor
    always_comb begin
        sum_x  = 18'(i_left) + 18'(i_right);
        sum_y  = 18'(i_top) + 18'(i_bottom);
        half_x = (sum_x + $signed(18'(sum_x[17]))) >>> 1;
        half_y = (sum_y + $signed(18'(sum_y[17]))) >>> 1;
        d_x    = half_x - 18'(i_cur_x);
        d_y    = half_y - 18'(i_cur_y);
    end

    // Shared squarer
    assign prod = r_d * r_d;

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            PH_IDLE: if (i_start) n_ph = PH_DX;
            PH_DX:   n_ph = PH_SQX;
            PH_SQX:  n_ph = PH_SQY;
            PH_SQY:  n_ph = PH_SUM;
            PH_SUM:  n_ph = PH_IDLE;
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    // Offset x, then dx squared, then dy squared, then sum
    always_ff @(posedge i_clk) begin
        unique case (r_ph)
            PH_DX: begin
                r_d <= d_x;
            end
            PH_SQX: begin
                r_sq <= prod[nrps_pkg::DistW-1:0];
                r_d  <= d_y;
            end
            PH_SQY: begin
                r_acc <= r_sq;
                r_sq  <= prod[nrps_pkg::DistW-1:0];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done = (r_ph == PH_SUM);
    assign o_dist = r_acc + r_sq;

endmodule

>>> sv/nested_rect_pick_selector.sv
// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+-----------------------------------------
// item      | in  | start & !busy                 | i_rect_x/y/w/h, i_cursor_x/y, i_last_item
// result    | out | o_valid, one cycle, no stall  | o_chosen_index, o_outcome, o_overflowed
//
// Each held item is loaded through the shared squarer, which forms dx^2 then dy^2.
// A dropped item (set full) is not stored. A final item then adds judging:
// 2 passes of n rows, each row taking its head entry and then one entry read per cycle,
// plus a setup step and a scan of up to n entries; the single entry read port paces
// the judging.
// Reset is synchronous, active low; it clears the sequencer, count and flags.
// busy stays high for the whole item; the result receiver cannot stall.
module nested_rect_pick_selector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic [14:0]        i_rect_w,
    input  logic [14:0]        i_rect_h,
    input  logic signed [15:0] i_cursor_x,
    input  logic signed [15:0] i_cursor_y,
    input  logic               i_last_item,
    output logic               o_valid,
    output logic [7:0]         o_chosen_index,
    output logic [1:0]         o_outcome,
    output logic               o_overflowed
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_JUDGE = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_HEAD  = 3'd4;
    localparam logic [2:0] S_PAIR  = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    nrps_pkg::t_cnt                 r_cnt;
    logic                           r_lost;
    logic                           r_last;
    logic                           r_pass;
    nrps_pkg::t_idx                 r_i;
    nrps_pkg::t_idx                 r_j;
    logic [nrps_pkg::MaxItems-1:0]  r_alive;
    logic signed [15:0]             r_cur_x;
    logic signed [15:0]             r_cur_y;
    nrps_pkg::t_entry               r_ent;
    nrps_pkg::t_entry               r_a;
    logic                           r_out_valid;
    logic [7:0]                     r_out_idx;
    logic [1:0]                     r_out_code;
    logic                           r_out_ovf;

    logic                           accept;
    logic                           room;
    logic signed [15:0]             cur_x;
    logic signed [15:0]             cur_y;
    nrps_pkg::t_cnt                 last_idx;
    logic                           j_end;
    logic                           i_end;
    logic                           hit;
    logic                           covers;
    logic                           farther;
    logic                           dist_done;
    logic [nrps_pkg::DistW-1:0]     dist_sum;
    nrps_pkg::t_entry               wdata;
    nrps_pkg::t_entry               rdata;
    nrps_pkg::t_idx                 raddr;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign room     = (r_cnt < nrps_pkg::CntW'(nrps_pkg::MaxItems));
    assign last_idx = r_cnt - nrps_pkg::CntW'(1);
    assign j_end    = (nrps_pkg::CntW'(r_j) == last_idx);
    assign i_end    = (nrps_pkg::CntW'(r_i) == last_idx);

    // Cursor comes from the first item of a set
    assign cur_x = (r_cnt == '0 && !r_lost) ? i_cursor_x : r_cur_x;
    assign cur_y = (r_cnt == '0 && !r_lost) ? i_cursor_y : r_cur_y;

    nrps_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_IDLE && accept && room),
        .i_left   (r_ent.left),
        .i_top    (r_ent.top),
        .i_right  (r_ent.right),
        .i_bottom (r_ent.bottom),
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .o_done   (dist_done),
        .o_dist   (dist_sum)
    );

    always_comb begin
        wdata         = r_ent;
        wdata.sq_dist = dist_sum;
    end

    // Entry read address per sequencer step
    always_comb begin
        unique case (r_state)
            S_ROW:   raddr = r_i;
            S_PAIR:  raddr = r_j + nrps_pkg::IdxW'(1);
            default: raddr = '0;
        endcase
    end

    nrps_store u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC && dist_done),
        .i_waddr (r_cnt[nrps_pkg::IdxW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Pair compare: row entry held in r_a, column entry streams from the store
    always_comb begin
        covers  = (r_a.left <= rdata.left) && (rdata.right <= r_a.right) &&
                  (r_a.top <= rdata.top) && (rdata.bottom <= r_a.bottom);
        farther = (r_a.sq_dist > rdata.sq_dist);
        hit     = (r_j != r_i) && r_alive[r_i] && r_alive[r_j] &&
                  (r_pass ? farther : covers);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (room)             n_state = S_CALC;
                    else if (i_last_item) n_state = S_JUDGE;
                end
            end
            S_CALC: begin
                if (dist_done) n_state = r_last ? S_JUDGE : S_IDLE;
            end
            S_JUDGE: begin
                n_state = (r_cnt <= nrps_pkg::CntW'(1)) ? S_IDLE : S_ROW;
            end
            S_ROW:  n_state = S_HEAD;
            S_HEAD: n_state = S_PAIR;
            S_PAIR: begin
                if (j_end) begin
                    if (!i_end)      n_state = S_ROW;
                    else if (r_pass) n_state = S_SCAN;
                    else             n_state = S_ROW;
                end
            end
            S_SCAN: begin
                if (r_alive[r_i] || i_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            priority if (r_state == S_IDLE && accept) begin
                r_cur_x <= cur_x;
                r_cur_y <= cur_y;
                if (!room) r_lost <= 1'b1;
            end else if (r_state == S_CALC && dist_done) begin
                r_cnt <= r_cnt + nrps_pkg::CntW'(1);
            end else if (r_state == S_JUDGE && r_cnt <= nrps_pkg::CntW'(1)) begin
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_lost      <= 1'b0;
            end else if (r_state == S_SCAN && (r_alive[r_i] || i_end)) begin
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_lost      <= 1'b0;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_last        <= i_last_item;
                r_ent.left    <= i_rect_x;
                r_ent.top     <= i_rect_y;
                r_ent.right   <= 17'(i_rect_x) + 17'(signed'({1'b0, i_rect_w})) - 17'sd1;
                r_ent.bottom  <= 17'(i_rect_y) + 17'(signed'({1'b0, i_rect_h})) - 17'sd1;
                r_ent.sq_dist <= '0;
                if (accept && room) begin
                    r_alive[r_cnt[nrps_pkg::IdxW-1:0]] <= (i_rect_w != '0) && (i_rect_h != '0);
                end
            end
            S_JUDGE: begin
                r_i        <= '0;
                r_pass     <= 1'b0;
                r_out_idx  <= '0;
                r_out_code <= nrps_pkg::OutSingle;
                r_out_ovf  <= r_lost;
            end
            S_HEAD: begin
                r_a <= rdata;
                r_j <= '0;
            end
            S_PAIR: begin
                if (hit) r_alive[r_i] <= 1'b0;
                r_j <= r_j + nrps_pkg::IdxW'(1);
                if (j_end) begin
                    if (!i_end) begin
                        r_i <= r_i + nrps_pkg::IdxW'(1);
                    end else begin
                        r_i    <= '0;
                        r_pass <= 1'b1;
                    end
                end
            end
            S_SCAN: begin
                r_i <= r_i + nrps_pkg::IdxW'(1);
                if (r_alive[r_i]) begin
                    r_out_idx  <= 8'(r_i);
                    r_out_code <= nrps_pkg::OutRule;
                end else begin
                    r_out_idx  <= '0;
                    r_out_code <= nrps_pkg::OutFallback;
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_outcome      = r_out_code;
    assign o_overflowed   = r_out_ovf;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= nrps_pkg::CntW'(nrps_pkg::MaxItems))
        else $error("item count beyond capacity");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE && r_cnt == '0 && !r_lost))
        else $error("result shown while set not closed");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe longer than one cycle");

    a_pair_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR) |-> (nrps_pkg::CntW'(r_i) < r_cnt &&
                                 nrps_pkg::CntW'(r_j) < r_cnt))
        else $error("pair index outside held set");

endmodule
